/* rtl/scbp_pkg.sv */
`timescale 1ns / 1ps
// scbp_pkg: types, sizes and codes of the structured control backpatcher
// depends on nothing; imported by structured_control_backpatcher_unit
package scbp_pkg;

  localparam int CODE_DEPTH  = 1024;
  localparam int STACK_DEPTH = 16;

  localparam int CODE_AW  = $clog2(CODE_DEPTH);
  localparam int CODE_CW  = $clog2(CODE_DEPTH + 1);
  localparam int PATCH_IW = $clog2(STACK_DEPTH);
  localparam int PATCH_CW = $clog2(STACK_DEPTH + 1);
  localparam int OP_W     = 8;
  localparam int ARG_W    = 16;
  localparam int KIND_W   = 4;

  localparam logic [KIND_W-1:0] KIND_PLAIN  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_IF     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_ELSE   = 4'd2;
  localparam logic [KIND_W-1:0] KIND_THEN   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_BEGIN  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_UNTIL  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_WHILE  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_REPEAT = 4'd7;
  localparam logic [KIND_W-1:0] KIND_FINISH = 4'd8;

  localparam logic CFG_JZ_OP  = 1'b0;
  localparam logic CFG_JMP_OP = 1'b1;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_BAD  = 2'd2
  } status_t;

  // patch stack entry kinds: if, else, begin and while
  typedef enum logic [1:0] {
    PK_IF    = 2'd0,
    PK_ELSE  = 2'd1,
    PK_BEGIN = 2'd2,
    PK_WHILE = 2'd3
  } patch_kind_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    patch_kind_t        kind;
    logic [CODE_AW-1:0] site;
    logic [CODE_CW-1:0] start;
  } stk_entry_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [OP_W-1:0]         plain_opcode;
    logic signed [ARG_W-1:0] plain_argument;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic                    append_valid;
    logic [CODE_AW-1:0]      append_address;
    logic [OP_W-1:0]         append_opcode;
    logic signed [ARG_W-1:0] append_argument;
    logic                    fixup_valid;
    logic [CODE_AW-1:0]      fixup_address;
    logic [CODE_CW-1:0]      fixup_target;
    logic [CODE_CW-1:0]      code_length;
    logic [PATCH_CW-1:0]     pending_depth;
  } out_item_t;

endpackage

/* rtl/structured_control_backpatcher_unit.sv */
`timescale 1ns / 1ps
// structured_control_backpatcher_unit: compiles if/else/then and begin loops
// into append and jump patch beats; depends on scbp_pkg
//
// Each item passes an accept step and a resolve step: on accept the top two
// entries of the patch stack memory are read into registers (synchronous
// read); in the resolve step the item is resolved, at most one stack entry is
// written back and the result goes to the output register. A new item is
// taken while a result still waits in that register; the resolve step holds
// only while the output register is full and not taken. Configuration writes
// take effect at once and may be made only while the block is idle.
module structured_control_backpatcher_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scbp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output scbp_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_addr,
  input  logic [7:0]           cfg_wdata
);
  import scbp_pkg::*;

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     jz_op_r, jmp_op_r;
  logic [CODE_CW-1:0]  code_count_r, code_count_nxt;
  logic [PATCH_CW-1:0] pending_count_r, pending_count_nxt;
  in_item_t            item_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r, res;

  stk_entry_t          stk_mem [STACK_DEPTH];
  stk_entry_t          top_r, second_r, wr_entry;
  logic                wr_en;
  logic [PATCH_IW-1:0] wr_addr;
  logic [PATCH_CW-1:0] cnt_m1, cnt_m2;

  logic in_fire, exec_go, code_full, stk_full;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cnt_m1    = pending_count_r - PATCH_CW'(1);
  assign cnt_m2    = pending_count_r - PATCH_CW'(2);
  assign code_full = code_count_r >= CODE_CW'(CODE_DEPTH);
  assign stk_full  = pending_count_r >= PATCH_CW'(STACK_DEPTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jz_op_r  <= '0;
      jmp_op_r <= OP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_JZ_OP:  jz_op_r  <= cfg_wdata;
        CFG_JMP_OP: jmp_op_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // patch stack memory
  always_ff @(posedge clk) begin
    if (in_fire) begin
      top_r    <= stk_mem[cnt_m1[PATCH_IW-1:0]];
      second_r <= stk_mem[cnt_m2[PATCH_IW-1:0]];
    end
    if (wr_en) begin
      stk_mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
    if (exec_go) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      code_count_r    <= '0;
      pending_count_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      code_count_r    <= code_count_nxt;
      pending_count_r <= pending_count_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt         = state_r;
    code_count_nxt    = code_count_r;
    pending_count_nxt = pending_count_r;
    res               = '0;
    wr_en             = 1'b0;
    wr_addr           = pending_count_r[PATCH_IW-1:0];
    wr_entry          = '0;
    out_valid_nxt     = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res.status    = STS_OK;
          case (item_r.kind)
            KIND_PLAIN: begin
              if (code_full) begin
                res.status = STS_FULL;
              end else begin
                res.append_valid    = 1'b1;
                res.append_address  = code_count_r[CODE_AW-1:0];
                res.append_opcode   = item_r.plain_opcode;
                res.append_argument = item_r.plain_argument;
                code_count_nxt      = code_count_r + CODE_CW'(1);
              end
            end
            KIND_IF: begin
              if (code_full) begin
                res.status = STS_FULL;
              end else begin
                res.append_valid   = 1'b1;
                res.append_address = code_count_r[CODE_AW-1:0];
                res.append_opcode  = jz_op_r;
                code_count_nxt     = code_count_r + CODE_CW'(1);
                if (stk_full) begin
                  res.status = STS_BAD;
                end else begin
                  wr_en             = 1'b1;
                  wr_entry.kind     = PK_IF;
                  wr_entry.site     = code_count_r[CODE_AW-1:0];
                  pending_count_nxt = pending_count_r + PATCH_CW'(1);
                end
              end
            end
            KIND_BEGIN: begin
              if (stk_full) begin
                res.status = STS_BAD;
              end else begin
                wr_en             = 1'b1;
                wr_entry.kind     = PK_BEGIN;
                wr_entry.site     = code_count_r[CODE_AW-1:0];
                wr_entry.start    = code_count_r;
                pending_count_nxt = pending_count_r + PATCH_CW'(1);
              end
            end
            KIND_FINISH: begin
              if (pending_count_r != '0) res.status = STS_BAD;
            end
            KIND_ELSE, KIND_THEN, KIND_UNTIL, KIND_WHILE, KIND_REPEAT: begin
              if (pending_count_r == '0) begin
                res.status = STS_BAD;
              end else begin
                pending_count_nxt = cnt_m1;
                if (item_r.kind == KIND_ELSE && top_r.kind == PK_IF) begin
                  res.fixup_valid   = 1'b1;
                  res.fixup_address = top_r.site;
                  res.fixup_target  = code_count_r + CODE_CW'(1);
                  if (code_full) begin
                    res.status = STS_FULL;
                  end else begin
                    res.append_valid   = 1'b1;
                    res.append_address = code_count_r[CODE_AW-1:0];
                    res.append_opcode  = jmp_op_r;
                    code_count_nxt     = code_count_r + CODE_CW'(1);
                    wr_en              = 1'b1;
                    wr_addr            = cnt_m1[PATCH_IW-1:0];
                    wr_entry.kind      = PK_ELSE;
                    wr_entry.site      = code_count_r[CODE_AW-1:0];
                    pending_count_nxt  = pending_count_r;
                  end
                end else if (item_r.kind == KIND_THEN &&
                             (top_r.kind == PK_IF || top_r.kind == PK_ELSE)) begin
                  res.fixup_valid   = 1'b1;
                  res.fixup_address = top_r.site;
                  res.fixup_target  = code_count_r;
                end else if (item_r.kind == KIND_UNTIL && top_r.kind == PK_BEGIN) begin
                  if (code_full) begin
                    res.status = STS_FULL;
                  end else begin
                    res.append_valid    = 1'b1;
                    res.append_address  = code_count_r[CODE_AW-1:0];
                    res.append_opcode   = jz_op_r;
                    res.append_argument = ARG_W'(top_r.start);
                    code_count_nxt      = code_count_r + CODE_CW'(1);
                  end
                end else if (item_r.kind == KIND_WHILE && top_r.kind == PK_BEGIN) begin
                  pending_count_nxt = pending_count_r;
                  if (code_full) begin
                    res.status = STS_FULL;
                  end else begin
                    res.append_valid   = 1'b1;
                    res.append_address = code_count_r[CODE_AW-1:0];
                    res.append_opcode  = jz_op_r;
                    code_count_nxt     = code_count_r + CODE_CW'(1);
                    if (stk_full) begin
                      res.status = STS_BAD;
                    end else begin
                      wr_en             = 1'b1;
                      wr_entry.kind     = PK_WHILE;
                      wr_entry.site     = code_count_r[CODE_AW-1:0];
                      wr_entry.start    = top_r.start;
                      pending_count_nxt = pending_count_r + PATCH_CW'(1);
                    end
                  end
                end else if (item_r.kind == KIND_REPEAT && top_r.kind == PK_WHILE &&
                             cnt_m1 != '0) begin
                  pending_count_nxt = cnt_m2;
                  if (second_r.kind != PK_BEGIN) begin
                    res.status = STS_BAD;
                  end else begin
                    res.fixup_valid   = 1'b1;
                    res.fixup_address = top_r.site;
                    res.fixup_target  = code_count_r + CODE_CW'(1);
                    if (code_full) begin
                      res.status = STS_FULL;
                    end else begin
                      res.append_valid    = 1'b1;
                      res.append_address  = code_count_r[CODE_AW-1:0];
                      res.append_opcode   = jmp_op_r;
                      res.append_argument = ARG_W'(second_r.start);
                      code_count_nxt      = code_count_r + CODE_CW'(1);
                    end
                  end
                end else begin
                  res.status = STS_BAD;
                end
              end
            end
            default: begin
              res.status = STS_BAD;
            end
          endcase
          res.code_length   = code_count_nxt;
          res.pending_depth = pending_count_nxt;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
